// ----- src/lfd_pkg.sv -----
// Shared types, constants and the level scaling function for the fade dimmer.
// No dependencies; every other file of the block but lfd_if.sv imports this package.
package lfd_pkg;

  localparam int unsigned LEVEL_W = 31;
  localparam int unsigned STEP_W  = 23;
  localparam int unsigned FADE_W  = 17;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned ELA_W   = 16;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned CNT_W   = 12;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX         = 31'h7fffffff;
  localparam logic [24:0]        LEVEL_PER_PERCENT = 25'd21474836;
  localparam logic [PCT_W-1:0]   PCT_FULL          = 7'd100;
  localparam logic [LEVEL_W-1:0] STEP_POS_LIMIT    = 31'd4194303;
  localparam logic [LEVEL_W-1:0] STEP_NEG_LIMIT    = 31'd4194304;
  localparam logic [STEP_W-1:0]  STEP_MIN          = 23'h400000;
  localparam logic [STEP_W-1:0]  STEP_MAX          = 23'h3fffff;
  localparam logic [ADDR_W-1:0]  REG_BASE          = 7'd6;
  localparam int unsigned        OFF_SHIFT         = 19;

  // Configuration register indexes.
  localparam logic CFG_FADE_TIME = 1'b0;
  localparam logic CFG_CHANNEL   = 1'b1;

  // Request codes.
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] dividend;
    logic [FADE_W-1:0]  divisor;
  } lfd_div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } lfd_div_rsp_t;

  // Linear percent to level mapping; zero and full scale are clamped.
  function automatic logic [LEVEL_W-1:0] level_of(input logic [PCT_W-1:0] p);
    logic [31:0] prod;
    prod = 32'(p) * 32'(LEVEL_PER_PERCENT);
    if (p == '0) begin
      return '0;
    end else if (p >= PCT_FULL) begin
      return LEVEL_MAX;
    end
    return prod[LEVEL_W-1:0];
  endfunction

endpackage

// ----- src/lfd_if.sv -----
// Valid/ready channel interfaces for the fade dimmer's request and result streams.
// Plain signals only; no package dependency.
interface lfd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [6:0]  percent;
  logic [15:0] elapsed_ms;

  modport source (output valid, output req_type, output percent, output elapsed_ms,
                  input ready);
  modport sink   (input valid, input req_type, input percent, input elapsed_ms,
                  output ready);
endinterface

interface lfd_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  reg_address;
  logic [11:0] off_count;

  modport source (output valid, output reg_address, output off_count, input ready);
  modport sink   (input valid, input reg_address, input off_count, output ready);
endinterface

// ----- src/lfd_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, for the fade step.
// Depends on lfd_pkg for widths and the request/response structs.
module lfd_div
  import lfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lfd_div_req_t req,
  output lfd_div_rsp_t rsp
);

  localparam int unsigned ITER_W = $clog2(LEVEL_W + 1);

  logic [FADE_W-1:0]  rem_r, rem_nxt;
  logic [LEVEL_W-1:0] quo_r, quo_nxt;
  logic [FADE_W-1:0]  dsr_r;
  logic [ITER_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [FADE_W:0]    shifted;
  logic               ge;

  // The dividend shifts out of the top of quo_r while quotient bits shift in.
  assign shifted = {rem_r, quo_r[LEVEL_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = ITER_W'(LEVEL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? FADE_W'(shifted - {1'b0, dsr_r}) : shifted[FADE_W-1:0];
      quo_nxt = {quo_r[LEVEL_W-2:0], ge};
      cnt_nxt = cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dsr_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- src/linear_fade_dimmer.sv -----
// Top level of the linear fade dimmer: request sequencer, level state and result register.
// Depends on lfd_pkg, the lfd_in_if/lfd_out_if interfaces and the lfd_div divider.
//
//   channel   direction  contents
//   in_ch     in         req_type, percent, elapsed_ms
//   out_ch    out        reg_address, off_count
//   cfg_*     in         cfg_we, cfg_index, cfg_wdata (fade_time_ms, channel_number)
//
// A set request that starts a fade keeps in_ch.ready low after acceptance through the decode
// states, the serial divider iterations, one per quotient bit, and the store of the saturated
// per-ms step. Other set requests and ticks keep it low through their own states (decode, level
// or step multiply, clamp add), plus any wait for the output register. in_ch.ready is high only
// while idle. A finished result waits in the output register; a later result stalls until
// it is taken. Reset is synchronous and clears all level state and both registers.
module linear_fade_dimmer
  import lfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lfd_in_if.sink            in_ch,
  lfd_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [FADE_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_A,
    S_SET_B,
    S_DIV,
    S_TICK,
    S_ADD,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [PCT_W-1:0]    pct_r;
  logic [ELA_W-1:0]    ela_r;
  logic [FADE_W-1:0]   fade_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [LEVEL_W-1:0]  cur_r;
  logic [LEVEL_W-1:0]  tgt_r;
  logic signed [STEP_W-1:0] step_r;
  logic [PCT_W-1:0]    last_r;
  logic                neg_r;
  logic signed [STEP_W+ELA_W:0] prod_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [PCT_W-1:0]    lvl_sel;
  logic [LEVEL_W-1:0]  lvl;
  logic                lvl_below;
  logic [LEVEL_W-1:0]  delta_mag;
  lfd_div_req_t        div_req;
  lfd_div_rsp_t        div_rsp;
  logic signed [LEVEL_W+9:0] sum;
  logic signed [LEVEL_W+9:0] tgt_s;
  logic signed [LEVEL_W+9:0] clamped;
  logic                out_free;
  logic [STEP_W-1:0]   step_sat;

  // One level multiplier, shared between the old and the new percent.
  assign lvl_sel   = (state_r == S_SET_A) ? last_r : pct_r;
  assign lvl       = level_of(lvl_sel);
  assign lvl_below = lvl < cur_r;
  assign delta_mag = lvl_below ? (cur_r - lvl) : (lvl - cur_r);

  assign div_req.start    = (state_r == S_SET_B) && (fade_r != '0) && (lvl != cur_r);
  assign div_req.dividend = delta_mag;
  assign div_req.divisor  = fade_r;

  lfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Saturate the quotient magnitude to the signed step range.
  always_comb begin
    if (!neg_r) begin
      step_sat = (div_rsp.quotient > STEP_POS_LIMIT) ? STEP_MAX
                                                     : div_rsp.quotient[STEP_W-1:0];
    end else begin
      step_sat = (div_rsp.quotient > STEP_NEG_LIMIT) ? STEP_MIN
                                                     : STEP_W'(-div_rsp.quotient[STEP_W-1:0]);
    end
  end

  // Advance and clamp; a positive step stops at the target from below,
  // otherwise from above.
  always_comb begin
    sum   = $signed({10'b0, cur_r}) + (LEVEL_W+10)'(prod_r);
    tgt_s = $signed({10'b0, tgt_r});
    clamped = sum;
    if (step_r > 0) begin
      if (sum > tgt_s) begin
        clamped = tgt_s;
      end
    end else begin
      if (sum < tgt_s) begin
        clamped = tgt_s;
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fade_r      <= '0;
      chan_r      <= '0;
      cur_r       <= '0;
      tgt_r       <= '0;
      step_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FADE_TIME: fade_r <= cfg_wdata;
          CFG_CHANNEL:   chan_r <= cfg_wdata[CHAN_W-1:0];
          default:       ;
        endcase
      end

      // In S_EMIT a taken result is replaced by the new one below.
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            pct_r   <= in_ch.percent;
            ela_r   <= in_ch.elapsed_ms;
            state_r <= (in_ch.req_type == REQ_TICK) ? S_TICK : S_SET_A;
          end
        end
        S_SET_A: begin
          cur_r   <= lvl;
          state_r <= (pct_r == last_r) ? S_EMIT : S_SET_B;
        end
        S_SET_B: begin
          last_r <= pct_r;
          tgt_r  <= lvl;
          neg_r  <= lvl_below;
          if (fade_r == '0) begin
            cur_r   <= lvl;
            state_r <= S_EMIT;
          end else if (lvl != cur_r) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            step_r  <= $signed(step_sat);
            state_r <= S_IDLE;
          end
        end
        S_TICK: begin
          if (cur_r == tgt_r) begin
            state_r <= S_IDLE;
          end else begin
            prod_r  <= step_r * $signed({1'b0, ela_r});
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          cur_r   <= clamped[LEVEL_W-1:0];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_addr_r  <= REG_BASE + {1'b0, chan_r, 2'b00};
            out_cnt_r   <= cur_r[LEVEL_W-1:OFF_SHIFT];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.reg_address = out_addr_r;
  assign out_ch.off_count   = out_cnt_r;

endmodule

// ----- dv/tb_linear_fade_dimmer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for linear_fade_dimmer: directed and random set and tick requests,
// with every emitted PWM register write compared against a cycle-free model of the ramp.
// Depends on lfd_pkg, the lfd_in_if/lfd_out_if interfaces and the linear_fade_dimmer RTL.
module tb_linear_fade_dimmer;
  import lfd_pkg::*;

  localparam logic [FADE_W-1:0] FADE_MAX_MS = 17'd127000;
  localparam int unsigned       SETTLE_CYCLES = 48;

  typedef struct packed {
    logic [ADDR_W-1:0] reg_address;
    logic [CNT_W-1:0]  off_count;
  } pwm_write_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [FADE_W-1:0] cfg_wdata;

  lfd_in_if  in_ch ();
  lfd_out_if out_ch ();

  linear_fade_dimmer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model state: registers and ramp state of the dimmer.
  logic [FADE_W-1:0]        fade_ms;
  logic [CHAN_W-1:0]        chan;
  logic [LEVEL_W-1:0]       cur_level;
  logic [LEVEL_W-1:0]       tgt_level;
  logic signed [STEP_W-1:0] step_ms;
  logic [PCT_W-1:0]         last_pct;

  pwm_write_t  pending_pwm_writes[$];
  int unsigned n_counted;
  int          errors;
  bit          src_gaps;
  bit          sink_stalls;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [LEVEL_W-1:0] pct_level(input logic [PCT_W-1:0] p);
    logic [31:0]        prod;
    logic [LEVEL_W-1:0] lvl;
    prod = 32'(p) * 32'(LEVEL_PER_PERCENT);
    if (p == '0) begin
      lvl = '0;
    end else if (p >= PCT_FULL) begin
      lvl = LEVEL_MAX;
    end else begin
      lvl = prod[LEVEL_W-1:0];
    end
    return lvl;
  endfunction

  // Advances the ramp by one request; returns 1 when the request yields a register write.
  function automatic bit predict_fade_step(input logic req, input logic [PCT_W-1:0] p,
                                           input logic [ELA_W-1:0] ela, output pwm_write_t wr);
    longint cur_l, tgt_l, div_l, ela_l, quot, nxt;
    bit     emits;
    emits = 1'b0;
    wr = '0;
    if (req == REQ_SET) begin
      cur_level = pct_level(last_pct);
      if (p == last_pct) begin
        emits = 1'b1;
      end else begin
        last_pct = p;
        tgt_level = pct_level(p);
        if (fade_ms == '0) begin
          cur_level = tgt_level;
          emits = 1'b1;
        end else if (cur_level != tgt_level) begin
          cur_l = longint'(cur_level);
          tgt_l = longint'(tgt_level);
          div_l = longint'(fade_ms);
          quot = (tgt_l - cur_l) / div_l;
          if (quot > longint'(STEP_POS_LIMIT)) quot = longint'(STEP_POS_LIMIT);
          if (quot < -longint'(STEP_NEG_LIMIT)) quot = -longint'(STEP_NEG_LIMIT);
          step_ms = quot[STEP_W-1:0];
        end
      end
    end else if (cur_level != tgt_level) begin
      cur_l = longint'(cur_level);
      tgt_l = longint'(tgt_level);
      ela_l = longint'(ela);
      nxt = cur_l + longint'(step_ms) * ela_l;
      // A rising ramp stops at the target from below it, any other one from above.
      if (step_ms > 0) begin
        if (nxt > tgt_l) nxt = tgt_l;
      end else begin
        if (nxt < tgt_l) nxt = tgt_l;
      end
      cur_level = nxt[LEVEL_W-1:0];
      emits = 1'b1;
    end
    if (emits) begin
      wr.reg_address = REG_BASE + {chan, 2'b00};
      wr.off_count = cur_level[LEVEL_W-1:OFF_SHIFT];
    end
    return emits;
  endfunction

  always @(posedge clk) begin
    pwm_write_t wr;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      n_counted++;
      if (predict_fade_step(in_ch.req_type, in_ch.percent, in_ch.elapsed_ms, wr)) begin
        pending_pwm_writes.push_back(wr);
      end
    end
  end

  always @(posedge clk) begin
    pwm_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pwm_writes.size() == 0) begin
        $display("%0t: unexpected write: addr %0d off %0d", $time, out_ch.reg_address,
                 out_ch.off_count);
        errors++;
      end else begin
        want = pending_pwm_writes.pop_front();
        if (out_ch.reg_address !== want.reg_address || out_ch.off_count !== want.off_count) begin
          $display("%0t: write mismatch: expected addr %0d off %0d, actual addr %0d off %0d",
                   $time, want.reg_address, want.off_count, out_ch.reg_address,
                   out_ch.off_count);
          errors++;
        end
      end
    end
  end

  // Result side backpressure.
  initial begin
    int unsigned n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_req(input logic req, input logic [PCT_W-1:0] p,
                          input logic [ELA_W-1:0] ela);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.percent    <= p;
    in_ch.elapsed_ms <= ela;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic set_pct(input logic [PCT_W-1:0] p);
    send_req(REQ_SET, p, ELA_W'($urandom));
  endtask

  task automatic tick(input logic [ELA_W-1:0] ela);
    send_req(REQ_TICK, PCT_W'($urandom), ela);
  endtask

  // A set that starts a ramp yields no write but keeps the divider busy for a while.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pwm_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [FADE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_FADE_TIME) begin
      fade_ms = val;
    end else begin
      chan = val[CHAN_W-1:0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [FADE_W-1:0] fade, input logic [CHAN_W-1:0] ch);
    wait_idle();
    write_cfg(CFG_FADE_TIME, fade);
    write_cfg(CFG_CHANNEL, FADE_W'(ch));
  endtask

  task automatic test_immediate_sets();
    configure('0, '0);
    set_pct(7'd0);
    set_pct(PCT_FULL);
    set_pct(7'd127);
    set_pct(7'd1);
    tick(16'hffff);
    set_pct(7'd99);
  endtask

  task automatic test_slow_fades();
    configure(FADE_MAX_MS, 4'd15);
    set_pct(7'd0);
    tick(16'd0);
    tick(16'hffff);
    tick(16'hffff);
    tick(16'd5);
    set_pct(PCT_FULL);
    tick(16'd1000);
    // Repeating the percent ends the ramp at its target.
    set_pct(PCT_FULL);
    // Above one hundred the level is the same, so no ramp starts.
    set_pct(7'd127);
    tick(16'd77);
  endtask

  task automatic test_step_saturation();
    configure(17'd1, 4'd7);
    set_pct(7'd0);
    tick(16'd100);
    tick(16'hffff);
    set_pct(PCT_FULL);
    tick(16'd1);
  endtask

  // The step of a ramp in progress keeps its value when the fade time is rewritten.
  task automatic test_fade_change_mid_ramp();
    wait_idle();
    write_cfg(CFG_FADE_TIME, FADE_MAX_MS);
    tick(16'd10);
    tick(16'hffff);
  endtask

  function automatic logic [PCT_W-1:0] pick_pct();
    logic [PCT_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = last_pct;
      1: p = PCT_W'($urandom_range(101, 127));
      2: p = $urandom_range(0, 1) ? PCT_FULL : 7'd0;
      default: p = PCT_W'($urandom_range(0, 100));
    endcase
    return p;
  endfunction

  function automatic logic [ELA_W-1:0] pick_elapsed();
    int unsigned span;
    logic [ELA_W-1:0] e;
    span = fade_ms / 3 + 1;
    if (span > 65535) span = 65535;
    case ($urandom_range(0, 9))
      0: e = '0;
      1, 2: e = ELA_W'($urandom_range(0, 65535));
      default: e = ELA_W'($urandom_range(0, span));
    endcase
    return e;
  endfunction

  task automatic random_settings();
    logic [FADE_W-1:0] f;
    case ($urandom_range(0, 7))
      0: f = '0;
      1: f = FADE_W'($urandom_range(1, 999));
      2: f = FADE_MAX_MS;
      3: f = FADE_W'($urandom_range(0, FADE_MAX_MS));
      default: f = FADE_W'($urandom_range(20, 4000));
    endcase
    configure(f, CHAN_W'($urandom_range(0, 15)));
  endtask

  // Mostly a set followed by ticks that walk the ramp; the rest is unrelated noise.
  task automatic test_random_ramps(input int unsigned goal);
    int unsigned stop_at, seqs, n_ticks;
    stop_at = n_counted + goal;
    while (n_counted < stop_at) begin
      random_settings();
      seqs = $urandom_range(8, 16);
      repeat (seqs) begin
        if ($urandom_range(0, 4) != 0) begin
          set_pct(pick_pct());
          n_ticks = $urandom_range(1, 8);
          repeat (n_ticks) tick(pick_elapsed());
        end else begin
          send_req(1'($urandom_range(0, 1)), PCT_W'($urandom), ELA_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_SET;
    in_ch.percent    <= '0;
    in_ch.elapsed_ms <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_FADE_TIME;
    cfg_wdata        <= '0;
    fade_ms     = '0;
    chan        = '0;
    cur_level   = '0;
    tgt_level   = '0;
    step_ms     = '0;
    last_pct    = '0;
    n_counted   = 0;
    errors      = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_immediate_sets();
    test_slow_fades();
    test_step_saturation();
    test_fade_change_mid_ramp();
    test_random_ramps(600);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_ramps(100);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pwm_writes.size() != 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_pwm_writes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
